/* design/assert_macros.svh */
// assertion macros included by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/llrp_pkg.sv */
// types, constants and control bundles of the replica placer
package llrp_pkg;

  localparam int NODES    = 16;
  localparam int REPLICAS = 3;
  localparam int NODE_W   = $clog2(NODES);
  localparam int LOAD_W   = 24;
  localparam int QUOTA_W  = 16;
  localparam int CHUNK_W  = 16;
  localparam int MASK_W   = 16;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = 5;
  localparam int GRP_SIZE = 4;
  localparam int GRP_N    = (NODES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int RND_W    = $clog2(REPLICAS + 1);
  localparam int ONL_W    = $clog2(NODES + 1);

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  // result status codes
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NO_NODE = 2'd1;
  localparam logic [1:0] ST_EXISTS  = 2'd2;

  // configuration port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_count;
    logic [MASK_W-1:0]  online_mask;
    logic               file_exists;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   node_index;
    logic [QUOTA_W-1:0] quota;
    logic [1:0]         status;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic grp;
    logic fin;
    logic upd;
    logic bulk;
    logic pend;
    logic emit;
    logic fail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fail_exists;
    logic fail_none;
    logic bulk_ok;
    logic rnd_last;
    logic fin_none;
    logic chunk_last;
    logic out_free;
    logic emit_last;
  } ctrl_stat_t;

endpackage

/* design/llrp_ctrl.sv */
// sequencing state machine of the replica placer
module llrp_ctrl import llrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_FAIL  = 9'b000000100,
    S_BULK  = 9'b000001000,
    S_GRP   = 9'b000010000,
    S_FIN   = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_PEND  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (stat.fail_exists || stat.fail_none) begin
          state_next = S_FAIL;
        end else if (stat.bulk_ok) begin
          state_next = S_BULK;
        end else begin
          state_next = S_GRP;
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.fail   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BULK: begin
        cmd.bulk   = 1'b1;
        state_next = S_PEND;
      end
      S_GRP: begin
        cmd.grp    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (stat.rnd_last || stat.fin_none) begin
          state_next = S_UPD;
        end else begin
          state_next = S_GRP;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (stat.chunk_last) begin
          state_next = S_PEND;
        end else begin
          state_next = S_GRP;
        end
      end
      S_PEND: begin
        cmd.pend   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/llrp_dp.sv */
// load table, minimum search, quota counters and result register
module llrp_dp import llrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output ctrl_stat_t       stat,
  input  in_word_t         in_word,
  input  logic [CNT_W-1:0] node_count,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  logic [LOAD_W-1:0]  node_load [NODES];
  logic [QUOTA_W-1:0] quota     [NODES];
  logic [CHUNK_W-1:0] chunks;
  logic [CHUNK_W-1:0] chunks_left;
  logic               exists;
  logic [NODES-1:0]   online;
  logic [NODES-1:0]   picked;
  logic [NODES-1:0]   pending;
  logic [RND_W-1:0]   rnd;

  logic [LOAD_W-1:0]  grp_load [GRP_N];
  logic [NODE_W-1:0]  grp_idx  [GRP_N];
  logic [GRP_N-1:0]   grp_ok;

  logic [LOAD_W-1:0]  g_load [GRP_N];
  logic [NODE_W-1:0]  g_idx  [GRP_N];
  logic [GRP_N-1:0]   g_ok;

  logic [LOAD_W-1:0]  fin_load;
  logic [NODE_W-1:0]  fin_idx;
  logic               fin_ok;

  logic [ONL_W-1:0]   online_ct;
  logic [NODE_W-1:0]  emit_idx;
  logic [NODES-1:0]   pend_rest;
  out_word_t          emit_word;
  out_word_t          fail_word;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [CHUNK_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + (LOAD_W + 1)'(b);
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

  // online count of the captured request
  always_comb begin
    online_ct = '0;
    for (int i = 0; i < NODES; i++) begin
      online_ct = online_ct + ONL_W'(online[i]);
    end
  end

  // first level: least loaded free node inside each group of four
  always_comb begin
    int n;
    for (int g = 0; g < GRP_N; g++) begin
      g_ok[g]   = 1'b0;
      g_load[g] = '0;
      g_idx[g]  = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        n = g * GRP_SIZE + j;
        if (n < NODES) begin
          if (online[n] && !picked[n] && (!g_ok[g] || node_load[n] < g_load[g])) begin
            g_ok[g]   = 1'b1;
            g_load[g] = node_load[n];
            g_idx[g]  = NODE_W'(n);
          end
        end
      end
    end
  end

  // second level: winner across the registered group results
  always_comb begin
    fin_ok   = 1'b0;
    fin_load = '0;
    fin_idx  = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (grp_ok[g] && (!fin_ok || grp_load[g] < fin_load)) begin
        fin_ok   = 1'b1;
        fin_load = grp_load[g];
        fin_idx  = grp_idx[g];
      end
    end
  end

  // lowest pending node goes out next
  always_comb begin
    emit_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        emit_idx = NODE_W'(i);
      end
    end
    pend_rest           = pending;
    pend_rest[emit_idx] = 1'b0;
  end

  always_comb begin
    emit_word.node_index = IDX_W'(emit_idx) + IDX_W'(1);
    emit_word.quota      = quota[emit_idx];
    emit_word.status     = ST_PLACED;
    emit_word.last       = (pend_rest == '0);
    fail_word.node_index = '0;
    fail_word.quota      = '0;
    fail_word.status     = stat.fail_exists ? ST_EXISTS : ST_NO_NODE;
    fail_word.last       = 1'b1;
  end

  always_comb begin
    stat.fail_exists = exists || (chunks == '0);
    stat.fail_none   = (online_ct == '0);
    stat.bulk_ok     = (online_ct <= ONL_W'(REPLICAS));
    stat.rnd_last    = (rnd == RND_W'(REPLICAS - 1));
    stat.fin_none    = !fin_ok;
    stat.chunk_last  = (chunks_left == CHUNK_W'(1));
    stat.out_free    = !out_valid || out_ready;
    stat.emit_last   = (pend_rest == '0);
  end

  // state with a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        node_load[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < NODES; i++) begin
        if (cmd.upd && picked[i]) begin
          node_load[i] <= sat_add(node_load[i], CHUNK_W'(1));
        end else if (cmd.bulk && online[i]) begin
          node_load[i] <= sat_add(node_load[i], chunks);
        end
      end
      if (cmd.emit || cmd.fail) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-request working registers, set up on capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chunks      <= in_word.chunk_count;
      chunks_left <= in_word.chunk_count;
      exists      <= in_word.file_exists;
      picked      <= '0;
      rnd         <= '0;
      for (int i = 0; i < NODES; i++) begin
        online[i] <= (node_count > CNT_W'(i)) && in_word.online_mask[i];
        quota[i]  <= '0;
      end
    end
    if (cmd.grp) begin
      for (int g = 0; g < GRP_N; g++) begin
        grp_ok[g]   <= g_ok[g];
        grp_load[g] <= g_load[g];
        grp_idx[g]  <= g_idx[g];
      end
    end
    if (cmd.fin) begin
      if (fin_ok) begin
        picked[fin_idx] <= 1'b1;
      end
      rnd <= rnd + RND_W'(1);
    end
    if (cmd.upd) begin
      for (int i = 0; i < NODES; i++) begin
        if (picked[i]) begin
          quota[i] <= quota[i] + QUOTA_W'(1);
        end
      end
      picked      <= '0;
      rnd         <= '0;
      chunks_left <= chunks_left - CHUNK_W'(1);
    end
    if (cmd.bulk) begin
      for (int i = 0; i < NODES; i++) begin
        if (online[i]) begin
          quota[i] <= chunks;
        end
      end
    end
    if (cmd.pend) begin
      for (int i = 0; i < NODES; i++) begin
        pending[i] <= (quota[i] != '0);
      end
    end else if (cmd.emit) begin
      pending <= pend_rest;
    end
    if (cmd.emit) begin
      out_word <= emit_word;
    end else if (cmd.fail) begin
      out_word <= fail_word;
    end
  end

endmodule

/* design/least_loaded_replica_placer_unit.sv */
// top level of the least loaded replica placer
//
//   port group      dir  word                         handshake
//   in_*            in   chunk_count, online_mask,    in_valid / in_ready
//                        file_exists
//   out_*           out  node_index, quota, status,   out_valid / out_ready
//                        last
//   p* (apb)        in   node_count at offset 0       psel / penable, pready tied high
//
// one request at a time: a capture step and a decision step, then per chunk
//   up to 3 picks through the two-level minimum search and an update,
//   or a single bulk update for all chunks when at most 3 nodes are online
// then a step to collect quotas, then the result words, lowest node first
// a failure word is loaded in the fail state; out_ready low stalls the
//   result register and holds the sequencer, in_ready returns once the last word is loaded
// rst is synchronous: all loads go to zero and node_count to 16
module least_loaded_replica_placer_unit import llrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // request words
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  `include "assert_macros.svh"

  logic [CNT_W-1:0] node_count;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;

  // single register, so every write lands in node_count
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = APB_DW'(node_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_wr) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  // sequencer
  llrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // load table, search and result register
  llrp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_word    (in_word),
    .node_count (node_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // failure words carry no node and close the request
  `ASSERT_CLK(a_fail_word, clk, rst, out_valid && out_word.status != ST_PLACED |-> out_word.node_index == '0 && out_word.quota == '0 && out_word.last, "failure word malformed")

  // placed words name a node in use and a nonzero quota
  `ASSERT_CLK(a_placed_word, clk, rst, out_valid && out_word.status == ST_PLACED |-> out_word.quota != '0 && out_word.node_index != '0 && out_word.node_index <= node_count, "placed word out of range")

  // a captured request blocks further requests through the decision state
  `ASSERT_CLK(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "request accepted while busy")

  // no status code beyond the three defined ones
  `ASSERT_NEVER(a_status_code, clk, rst, out_valid && out_word.status == 2'd3, "undefined status code")

endmodule
